// ===== sv/ctca_pkg.sv =====
package ctca_pkg;

	// Size of the count matrices
	localparam int NUM_BINS    = 8;
	localparam int ALPHABET    = 20;
	localparam int PAIRS       = ALPHABET * ALPHABET;
	localparam int MAT_ENTRIES = PAIRS * PAIRS;
	localparam int CNT_DEPTH   = NUM_BINS * MAT_ENTRIES;

	// Widths that follow from the sizes
	localparam int ADDR_W = $clog2(CNT_DEPTH);
	localparam int PAIR_W = $clog2(PAIRS);
	localparam int PCMP_W = $clog2(PAIRS + 1);

	// Fixed field widths
	localparam int PT_DEPTH = 8;
	localparam int BSEL_W   = 3;
	localparam int RES_W    = 5;
	localparam int RLIM_W   = RES_W + 1;
	localparam int LEN_W    = 32;
	localparam int CNT_W    = 32;
	localparam int NPT_W    = 4;

	localparam logic [CNT_W-1:0] CNT_MAX  = '1;
	localparam logic signed [3:0] BIN_NONE = -4'sd1;

	// Amounts in quarter units
	localparam logic [1:0] AMT_EDGE   = 2'd2;
	localparam logic [1:0] AMT_CHERRY = 2'd1;

	// Configuration register indexes
	localparam logic [1:0] CFG_COUNT_MODE = 2'd0;
	localparam logic [1:0] CFG_ALPHA_SIZE = 2'd1;
	localparam logic [1:0] CFG_NUM_POINTS = 2'd2;

	localparam logic [RES_W-1:0] ALPHA_SIZE_RST = 5'd20;
	localparam logic [NPT_W-1:0] NUM_POINTS_RST = 4'd8;

	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_COUNT = 2'd1,
		REQ_READ  = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_COUNT,
		OP_READ
	} op_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_CMP,
		F_MUL,
		F_CLS
	} fstate_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_ADDR,
		B_RD,
		B_WR
	} bstate_t;

	typedef struct packed {
		logic             count_mode;
		logic [RES_W-1:0] alpha_size;
		logic [NPT_W-1:0] num_points;
	} cfg_t;

	// Command passed from classifier to executor
	typedef struct packed {
		op_t               op;
		logic              mode;
		logic [BSEL_W-1:0] bin;
		logic [PAIR_W-1:0] row0;
		logic [PAIR_W-1:0] col0;
		logic [PAIR_W-1:0] row1;
		logic [PAIR_W-1:0] col1;
		logic signed [3:0] bin_hit;
	} cmd_t;

	localparam int CQ_DEPTH = 2;
	localparam int CQ_PTR_W = $clog2(CQ_DEPTH);

endpackage

// ===== sv/ctca_front.sv =====
module ctca_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ctca_pkg::cfg_t                cfg,
	input  logic                          push,
	output logic                          busy,
	input  logic [1:0]                    req_type,
	input  logic [ctca_pkg::BSEL_W-1:0]   bin_select,
	input  logic [ctca_pkg::LEN_W-1:0]    point_value,
	input  logic [ctca_pkg::LEN_W-1:0]    length_a,
	input  logic [ctca_pkg::LEN_W-1:0]    length_b,
	input  logic [ctca_pkg::RES_W-1:0]    start_first_residue,
	input  logic [ctca_pkg::RES_W-1:0]    start_second_residue,
	input  logic [ctca_pkg::RES_W-1:0]    end_first_residue,
	input  logic [ctca_pkg::RES_W-1:0]    end_second_residue,
	input  logic [ctca_pkg::PAIR_W-1:0]   read_row,
	input  logic [ctca_pkg::PAIR_W-1:0]   read_col,
	output logic                          q_push,
	input  logic                          q_full,
	output ctca_pkg::cmd_t                q_cmd
);

	localparam int PTD = ctca_pkg::PT_DEPTH;
	localparam int PIW = $clog2(PTD);
	localparam int BSEL_W_LOCAL = ctca_pkg::BSEL_W;
	localparam logic [ctca_pkg::NPT_W-1:0] NPT_W_CAP = ctca_pkg::NPT_W'(ctca_pkg::NUM_BINS);

	ctca_pkg::fstate_t state_q, state_d;

	logic [ctca_pkg::LEN_W-1:0]  pt_q [PTD];
	ctca_pkg::req_t              req_q;
	logic                        mode_q;
	logic [ctca_pkg::BSEL_W-1:0] bsel_q;
	logic [ctca_pkg::LEN_W:0]    len_q;
	logic [ctca_pkg::RES_W-1:0]  s1_q, s2_q, e1_q, e2_q;
	logic [ctca_pkg::PAIR_W-1:0] rr_q, rc_q;
	logic                        miss_q;
	logic [PIW-1:0]              idx_q;
	logic [ctca_pkg::LEN_W-1:0]  plo_q, phi_q;
	logic [2*ctca_pkg::LEN_W-1:0] sq_q, pr_q;

	logic                        accept;
	logic [ctca_pkg::NPT_W-1:0]  n_eff;
	logic [PTD-1:0]              ge, in_use, is_last, first_hit;
	logic                        found, lo_out, hi_out, miss_d;
	logic [PIW-1:0]              idx_d;
	logic [ctca_pkg::LEN_W-1:0]  plo_d, phi_d;
	logic [ctca_pkg::RLIM_W-1:0] lim;
	logic                        res_ok, rd_ok;
	logic [BSEL_W_LOCAL-1:0]     bin_d;

	assign accept = push && !busy;
	assign busy   = (state_q != ctca_pkg::F_IDLE);

	// Advance the classifier
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ctca_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		q_push  = 1'b0;
		unique case (state_q)
			ctca_pkg::F_IDLE: begin
				if (accept) begin
					state_d = ctca_pkg::F_CMP;
				end
			end
			ctca_pkg::F_CMP: state_d = ctca_pkg::F_MUL;
			ctca_pkg::F_MUL: state_d = ctca_pkg::F_CLS;
			ctca_pkg::F_CLS: begin
				if (!q_full) begin
					q_push  = 1'b1;
					state_d = ctca_pkg::F_IDLE;
				end
			end
			default: state_d = ctca_pkg::F_IDLE;
		endcase
	end

	// Store a quantization point on a load request
	always_ff @(posedge clk) begin
		if (accept && ctca_pkg::req_t'(req_type) == ctca_pkg::REQ_LOAD
				&& {1'b0, bin_select} < 4'(ctca_pkg::NUM_BINS)) begin
			pt_q[bin_select] <= point_value;
		end
	end

	// Capture the request and its effective length
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= ctca_pkg::req_t'(req_type);
			mode_q <= cfg.count_mode;
			bsel_q <= bin_select;
			len_q  <= cfg.count_mode ? ({1'b0, length_a} + {1'b0, length_b})
			                         : {1'b0, length_a};
			s1_q   <= start_first_residue;
			s2_q   <= start_second_residue;
			e1_q   <= end_first_residue;
			e2_q   <= end_second_residue;
			rr_q   <= read_row;
			rc_q   <= read_col;
		end
	end

	// Compare the length against every point in use
	always_comb begin
		n_eff = (cfg.num_points > NPT_W_CAP) ? NPT_W_CAP : cfg.num_points;
		found = 1'b0;
		for (int j = 0; j < PTD; j++) begin
			ge[j]      = ({1'b0, pt_q[j]} >= len_q);
			in_use[j]  = (ctca_pkg::NPT_W'(j) < n_eff);
			is_last[j] = (ctca_pkg::NPT_W'(j + 1) == n_eff);
			first_hit[j] = ge[j] && in_use[j] && !found;
			found        = found || (ge[j] && in_use[j]);
		end
		lo_out = ({1'b0, pt_q[0]} > len_q);
		hi_out = |(is_last & ~ge);
		miss_d = (n_eff == '0) || lo_out || hi_out || !found;
		idx_d  = '0;
		plo_d  = '0;
		phi_d  = '0;
		for (int j = 0; j < PTD; j++) begin
			if (first_hit[j]) begin
				idx_d = PIW'(j);
			end
			phi_d = phi_d | (first_hit[j] ? pt_q[j] : '0);
			if (j + 1 < PTD) begin
				plo_d = plo_d | (first_hit[j+1] ? pt_q[j] : '0);
			end
		end
	end

	// Hold the bracketing points, then form both products
	always_ff @(posedge clk) begin
		if (state_q == ctca_pkg::F_CMP) begin
			miss_q <= miss_d;
			idx_q  <= idx_d;
			plo_q  <= plo_d;
			phi_q  <= phi_d;
		end
		if (state_q == ctca_pkg::F_MUL) begin
			sq_q <= len_q[ctca_pkg::LEN_W-1:0] * len_q[ctca_pkg::LEN_W-1:0];
			pr_q <= plo_q * phi_q;
		end
	end

	// Pick the bin and check the residues and read ranges
	always_comb begin
		if (idx_q == '0) begin
			bin_d = '0;
		end else if (sq_q < pr_q) begin
			bin_d = BSEL_W_LOCAL'(idx_q - 1'b1);
		end else begin
			bin_d = BSEL_W_LOCAL'(idx_q);
		end
		lim = (ctca_pkg::RLIM_W'(cfg.alpha_size) < ctca_pkg::RLIM_W'(ctca_pkg::ALPHABET))
		    ? ctca_pkg::RLIM_W'(cfg.alpha_size) : ctca_pkg::RLIM_W'(ctca_pkg::ALPHABET);
		res_ok = (ctca_pkg::RLIM_W'(s1_q) < lim) && (ctca_pkg::RLIM_W'(s2_q) < lim)
		      && (ctca_pkg::RLIM_W'(e1_q) < lim) && (ctca_pkg::RLIM_W'(e2_q) < lim);
		rd_ok = ({1'b0, bsel_q} < 4'(ctca_pkg::NUM_BINS))
		     && (ctca_pkg::PCMP_W'(rr_q) < ctca_pkg::PCMP_W'(ctca_pkg::PAIRS))
		     && (ctca_pkg::PCMP_W'(rc_q) < ctca_pkg::PCMP_W'(ctca_pkg::PAIRS));
	end

	// Build the command for the executor
	always_comb begin
		q_cmd         = '0;
		q_cmd.op      = ctca_pkg::OP_NONE;
		q_cmd.mode    = mode_q;
		q_cmd.bin_hit = ctca_pkg::BIN_NONE;
		q_cmd.bin     = bsel_q;
		q_cmd.row0    = rr_q;
		q_cmd.col0    = rc_q;
		case (req_q)
			ctca_pkg::REQ_COUNT: begin
				q_cmd.bin  = bin_d;
				q_cmd.row0 = ctca_pkg::PAIR_W'(s1_q) * ctca_pkg::PAIR_W'(ctca_pkg::ALPHABET)
				           + ctca_pkg::PAIR_W'(s2_q);
				q_cmd.col0 = ctca_pkg::PAIR_W'(e1_q) * ctca_pkg::PAIR_W'(ctca_pkg::ALPHABET)
				           + ctca_pkg::PAIR_W'(e2_q);
				q_cmd.row1 = ctca_pkg::PAIR_W'(s2_q) * ctca_pkg::PAIR_W'(ctca_pkg::ALPHABET)
				           + ctca_pkg::PAIR_W'(s1_q);
				q_cmd.col1 = ctca_pkg::PAIR_W'(e2_q) * ctca_pkg::PAIR_W'(ctca_pkg::ALPHABET)
				           + ctca_pkg::PAIR_W'(e1_q);
				if (!miss_q) begin
					q_cmd.bin_hit = $signed({1'b0, bin_d});
					if (res_ok) begin
						q_cmd.op = ctca_pkg::OP_COUNT;
					end
				end
			end
			ctca_pkg::REQ_READ: begin
				if (rd_ok) begin
					q_cmd.op = ctca_pkg::OP_READ;
				end
			end
			default: q_cmd.op = ctca_pkg::OP_NONE;
		endcase
	end

endmodule

// ===== sv/ctca_cmdq.sv =====
module ctca_cmdq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ctca_pkg::cmd_t din,
	output logic           full,
	input  logic           pop,
	output ctca_pkg::cmd_t dout,
	output logic           empty
);

	localparam int PW = ctca_pkg::CQ_PTR_W;
	localparam int CW = $clog2(ctca_pkg::CQ_DEPTH + 1);

	ctca_pkg::cmd_t slot_q [ctca_pkg::CQ_DEPTH];
	logic [PW-1:0]  wptr_q, rptr_q;
	logic [CW-1:0]  cnt_q;
	logic           do_push, do_pop;

	assign full    = (cnt_q == CW'(ctca_pkg::CQ_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = slot_q[rptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(ctca_pkg::CQ_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(ctca_pkg::CQ_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
		end
	end

	// Hold commands
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wptr_q] <= din;
		end
	end

endmodule

// ===== sv/ctca_back.sv =====
module ctca_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_empty,
	input  ctca_pkg::cmd_t                     q_cmd,
	output logic                               q_pop,
	output logic                               clearing,
	output logic                               empty,
	input  logic                               pop,
	output logic [ctca_pkg::CNT_W-1:0]         count_value,
	output logic signed [3:0]                  bin_hit,
	output logic                               counted,
	output logic                               saturated
);

	localparam int AW = ctca_pkg::ADDR_W;
	localparam int PW = ctca_pkg::PAIR_W;

	ctca_pkg::bstate_t state_q, state_d;

	logic [ctca_pkg::CNT_W-1:0] mem_q [ctca_pkg::CNT_DEPTH];
	logic [ctca_pkg::CNT_W-1:0] rdata_q;
	logic [AW-1:0]              addr_q, addr_d;
	ctca_pkg::cmd_t             cmd_q;
	logic [1:0]                 k_q;
	logic                       hit_q;
	logic                       out_valid_q;

	logic                       slot_free, mem_we, res_load, last, pair_sel, swap, sat_now;
	logic [PW-1:0]              pr_row, pr_col, row, col;
	logic [1:0]                 amt;
	logic [ctca_pkg::CNT_W:0]   sum;
	logic [ctca_pkg::CNT_W-1:0] mem_wdata;
	logic [ctca_pkg::CNT_W-1:0] res_value;
	logic signed [3:0]          res_bin;
	logic                       res_cnt, res_sat;

	assign clearing  = (state_q == ctca_pkg::B_CLEAR);
	assign empty     = !out_valid_q;
	assign slot_free = !out_valid_q || pop;

	// Select the entry of the current update
	always_comb begin
		pair_sel = cmd_q.mode ? k_q[1] : k_q[0];
		swap     = cmd_q.mode && k_q[0];
		last     = cmd_q.mode ? (k_q == 2'd3) : (k_q == 2'd1);
		amt      = cmd_q.mode ? ctca_pkg::AMT_CHERRY : ctca_pkg::AMT_EDGE;
		pr_row   = pair_sel ? cmd_q.row1 : cmd_q.row0;
		pr_col   = pair_sel ? cmd_q.col1 : cmd_q.col0;
		row      = swap ? pr_col : pr_row;
		col      = swap ? pr_row : pr_col;
		addr_d   = AW'(cmd_q.bin) * AW'(ctca_pkg::MAT_ENTRIES)
		         + AW'(row) * AW'(ctca_pkg::PAIRS) + AW'(col);
		sum      = {1'b0, rdata_q} + (ctca_pkg::CNT_W + 1)'(amt);
		sat_now  = (sum >= {1'b0, ctca_pkg::CNT_MAX});
		mem_wdata = clearing ? '0 : (sat_now ? ctca_pkg::CNT_MAX : sum[ctca_pkg::CNT_W-1:0]);
	end

	// Sequence the memory updates
	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		mem_we    = 1'b0;
		res_load  = 1'b0;
		res_value = '0;
		res_bin   = cmd_q.bin_hit;
		res_cnt   = 1'b0;
		res_sat   = 1'b0;
		unique case (state_q)
			ctca_pkg::B_CLEAR: begin
				mem_we = 1'b1;
				if (addr_q == AW'(ctca_pkg::CNT_DEPTH - 1)) begin
					state_d = ctca_pkg::B_IDLE;
				end
			end
			ctca_pkg::B_IDLE: begin
				if (!q_empty && slot_free) begin
					q_pop = 1'b1;
					unique case (q_cmd.op)
						ctca_pkg::OP_NONE: begin
							res_load = 1'b1;
							res_bin  = q_cmd.bin_hit;
						end
						ctca_pkg::OP_COUNT,
						ctca_pkg::OP_READ: state_d = ctca_pkg::B_ADDR;
						default: state_d = ctca_pkg::B_IDLE;
					endcase
				end
			end
			ctca_pkg::B_ADDR: state_d = ctca_pkg::B_RD;
			ctca_pkg::B_RD:   state_d = ctca_pkg::B_WR;
			ctca_pkg::B_WR: begin
				if (cmd_q.op == ctca_pkg::OP_READ) begin
					res_load  = 1'b1;
					res_value = rdata_q;
					state_d   = ctca_pkg::B_IDLE;
				end else begin
					mem_we = 1'b1;
					if (last) begin
						res_load = 1'b1;
						res_cnt  = 1'b1;
						res_sat  = hit_q || sat_now;
						state_d  = ctca_pkg::B_IDLE;
					end else begin
						state_d = ctca_pkg::B_ADDR;
					end
				end
			end
			default: state_d = ctca_pkg::B_IDLE;
		endcase
	end

	// Advance control state; sweep the store clear after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ctca_pkg::B_CLEAR;
			addr_q      <= '0;
			k_q         <= '0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ctca_pkg::B_CLEAR) begin
				addr_q <= addr_q + 1'b1;
			end else if (state_q == ctca_pkg::B_ADDR) begin
				addr_q <= addr_d;
			end
			if (q_pop) begin
				k_q   <= '0;
				hit_q <= 1'b0;
			end else if (state_q == ctca_pkg::B_WR && cmd_q.op == ctca_pkg::OP_COUNT) begin
				k_q   <= k_q + 1'b1;
				hit_q <= hit_q || sat_now;
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the command and the result
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
		end
		if (res_load) begin
			count_value <= res_value;
			bin_hit     <= res_bin;
			counted     <= res_cnt;
			saturated   <= res_sat;
		end
	end

	// Count store: one port, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[addr_q] <= mem_wdata;
		end
		rdata_q <= mem_q[addr_q];
	end

endmodule

// ===== sv/co_transition_count_accumulator.sv =====
// A request passes the classifier states compare, multiply and classify, then the
// command queue, then the executor; a read or a count adds the address, read and write
// states, once per store update for a count (two in edge mode, four in cherry mode).
// The classifier takes no new request until it has handed the last one to the command
// queue, and the executor pops the next command only once it is through with the last,
// each count update being a read-modify-write of the single-port count store.
// Reset: asynchronous; the count store is then swept to zero, with full held high.
module co_transition_count_accumulator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [1:0]                       cfg_index,
	input  logic [ctca_pkg::RES_W-1:0]       cfg_data,
	input  logic                             push,
	output logic                             full,
	input  logic [1:0]                       req_type,
	input  logic [ctca_pkg::BSEL_W-1:0]      bin_select,
	input  logic [ctca_pkg::LEN_W-1:0]       point_value,
	input  logic [ctca_pkg::LEN_W-1:0]       length_a,
	input  logic [ctca_pkg::LEN_W-1:0]       length_b,
	input  logic [ctca_pkg::RES_W-1:0]       start_first_residue,
	input  logic [ctca_pkg::RES_W-1:0]       start_second_residue,
	input  logic [ctca_pkg::RES_W-1:0]       end_first_residue,
	input  logic [ctca_pkg::RES_W-1:0]       end_second_residue,
	input  logic [ctca_pkg::PAIR_W-1:0]      read_row,
	input  logic [ctca_pkg::PAIR_W-1:0]      read_col,
	output logic                             empty,
	input  logic                             pop,
	output logic [ctca_pkg::CNT_W-1:0]       count_value,
	output logic signed [3:0]                bin_hit,
	output logic                             counted,
	output logic                             saturated
);

	ctca_pkg::cfg_t cfg_q;
	ctca_pkg::cmd_t fq_cmd, qb_cmd;
	logic           front_busy, clearing;
	logic           fq_push, fq_full, qb_empty, qb_pop;

	assign cfg_ready = 1'b1;
	assign full      = front_busy || clearing;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.count_mode <= 1'b0;
			cfg_q.alpha_size <= ctca_pkg::ALPHA_SIZE_RST;
			cfg_q.num_points <= ctca_pkg::NUM_POINTS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ctca_pkg::CFG_COUNT_MODE: cfg_q.count_mode <= cfg_data[0];
				ctca_pkg::CFG_ALPHA_SIZE: cfg_q.alpha_size <= cfg_data;
				ctca_pkg::CFG_NUM_POINTS: cfg_q.num_points <= cfg_data[ctca_pkg::NPT_W-1:0];
				default: ;
			endcase
		end
	end

	ctca_front u_front (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg                  (cfg_q),
		.push                 (push && !clearing),
		.busy                 (front_busy),
		.req_type             (req_type),
		.bin_select           (bin_select),
		.point_value          (point_value),
		.length_a             (length_a),
		.length_b             (length_b),
		.start_first_residue  (start_first_residue),
		.start_second_residue (start_second_residue),
		.end_first_residue    (end_first_residue),
		.end_second_residue   (end_second_residue),
		.read_row             (read_row),
		.read_col             (read_col),
		.q_push               (fq_push),
		.q_full               (fq_full),
		.q_cmd                (fq_cmd)
	);

	ctca_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fq_push),
		.din    (fq_cmd),
		.full   (fq_full),
		.pop    (qb_pop),
		.dout   (qb_cmd),
		.empty  (qb_empty)
	);

	ctca_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (qb_empty),
		.q_cmd       (qb_cmd),
		.q_pop       (qb_pop),
		.clearing    (clearing),
		.empty       (empty),
		.pop         (pop),
		.count_value (count_value),
		.bin_hit     (bin_hit),
		.counted     (counted),
		.saturated   (saturated)
	);

	// A counted result always names a bin
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && counted) |-> (bin_hit != ctca_pkg::BIN_NONE))
		else $error("counted result without a bin");

	// Saturation is only reported for a counted update
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && saturated) |-> counted)
		else $error("saturated without counted");

	// A nonzero count comes only from a read
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && count_value != '0) |-> (!counted && bin_hit == ctca_pkg::BIN_NONE))
		else $error("count value on a non-read result");

	// No request is taken while the store is being cleared
	assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> full)
		else $error("request accepted during clear");

endmodule

// ===== test/tb_co_transition_count_accumulator.sv =====
module tb_co_transition_count_accumulator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 4_000_000;
	localparam int          NUM_PHASES  = 10;
	localparam int          PHASE_ITEMS = 72;
	localparam int          HOLDOFF_LEN = 400;

	// Register settings of the random phases, extremes and out-of-range values included
	localparam bit       PHASE_MODE   [NUM_PHASES] = '{0, 1, 0, 1, 0, 1, 0, 1, 0, 1};
	localparam bit [4:0] PHASE_STATES [NUM_PHASES] = '{20, 20, 1, 5, 31, 0, 20, 20, 12, 20};
	localparam bit [3:0] PHASE_POINTS [NUM_PHASES] = '{8, 8, 8, 3, 15, 8, 0, 1, 5, 8};

	typedef struct {
		ctca_pkg::req_t                kind;
		logic [ctca_pkg::BSEL_W-1:0]   bin_select;
		logic [ctca_pkg::LEN_W-1:0]    point_value;
		logic [ctca_pkg::LEN_W-1:0]    length_a;
		logic [ctca_pkg::LEN_W-1:0]    length_b;
		logic [ctca_pkg::RES_W-1:0]    s1;
		logic [ctca_pkg::RES_W-1:0]    s2;
		logic [ctca_pkg::RES_W-1:0]    e1;
		logic [ctca_pkg::RES_W-1:0]    e2;
		logic [ctca_pkg::PAIR_W-1:0]   rrow;
		logic [ctca_pkg::PAIR_W-1:0]   rcol;
	} request_t;

	typedef struct {
		logic [ctca_pkg::CNT_W-1:0]    count_value;
		logic signed [3:0]             bin_hit;
		logic                          counted;
		logic                          saturated;
	} result_t;

	// Tracks the point table and count matrices, and holds the expected results in order
	class tally_board;
		bit [ctca_pkg::LEN_W-1:0] points [ctca_pkg::PT_DEPTH];
		bit [ctca_pkg::CNT_W-1:0] tally [int unsigned];
		bit                       cherry_mode;
		bit [ctca_pkg::RES_W-1:0] state_limit;
		bit [ctca_pkg::NPT_W-1:0] point_count;
		result_t                  pending [$];
		int unsigned              recent_keys [$];
		int unsigned              mismatches;

		function new();
			foreach (points[k]) points[k] = '0;
			cherry_mode = 1'b0;
			state_limit = ctca_pkg::ALPHA_SIZE_RST;
			point_count = ctca_pkg::NUM_POINTS_RST;
			mismatches  = 0;
		endfunction

		function void set_register(logic [1:0] idx, logic [ctca_pkg::RES_W-1:0] data);
			case (idx)
				ctca_pkg::CFG_COUNT_MODE: cherry_mode = data[0];
				ctca_pkg::CFG_ALPHA_SIZE: state_limit = data;
				ctca_pkg::CFG_NUM_POINTS: point_count = data[ctca_pkg::NPT_W-1:0];
				default: ;
			endcase
		endfunction

		// Nearest point by relative error: compare len^2 against the neighbors' product
		function int quantize(bit [ctca_pkg::LEN_W:0] len);
			int unsigned n, i;
			bit [63:0] sq, prod;
			n = (point_count > ctca_pkg::NUM_BINS) ? ctca_pkg::NUM_BINS : point_count;
			if (n == 0) return -1;
			if (len < {1'b0, points[0]} || len > {1'b0, points[n-1]}) return -1;
			i = 0;
			while (i < n && {1'b0, points[i]} < len) i++;
			if (i == 0) return 0;
			sq   = 64'(len[ctca_pkg::LEN_W-1:0]) * 64'(len[ctca_pkg::LEN_W-1:0]);
			prod = 64'(points[i-1]) * 64'(points[i]);
			return (sq < prod) ? int'(i - 1) : int'(i);
		endfunction

		// Saturating add of quarter units to one entry; flag when the maximum is hit
		function bit add_quarters(int unsigned bin, int unsigned row, int unsigned col,
				bit [1:0] amt);
			int unsigned key;
			bit [ctca_pkg::CNT_W-1:0] cur;
			bit [ctca_pkg::CNT_W:0] sum;
			key = bin * ctca_pkg::MAT_ENTRIES + row * ctca_pkg::PAIRS + col;
			cur = tally.exists(key) ? tally[key] : '0;
			sum = {1'b0, cur} + (ctca_pkg::CNT_W+1)'(amt);
			if (sum >= {1'b0, ctca_pkg::CNT_MAX}) begin
				tally[key] = ctca_pkg::CNT_MAX;
				return 1'b1;
			end
			tally[key] = sum[ctca_pkg::CNT_W-1:0];
			return 1'b0;
		endfunction

		function void note_request(request_t r);
			result_t     want;
			int          bin;
			bit [ctca_pkg::LEN_W:0] len;
			int unsigned lim, st, en, rst, ren, key;
			bit          hit;
			want.count_value = '0;
			want.bin_hit     = ctca_pkg::BIN_NONE;
			want.counted     = 1'b0;
			want.saturated   = 1'b0;
			case (r.kind)
				ctca_pkg::REQ_LOAD: begin
					if (r.bin_select < ctca_pkg::NUM_BINS) points[r.bin_select] = r.point_value;
				end
				ctca_pkg::REQ_COUNT: begin
					len = cherry_mode ? {1'b0, r.length_a} + {1'b0, r.length_b}
						: {1'b0, r.length_a};
					bin = quantize(len);
					if (bin >= 0) begin
						want.bin_hit = 4'(bin);
						lim = (state_limit < ctca_pkg::ALPHABET) ? state_limit
							: ctca_pkg::ALPHABET;
						if (r.s1 < lim && r.s2 < lim && r.e1 < lim && r.e2 < lim) begin
							st  = r.s1 * ctca_pkg::ALPHABET + r.s2;
							en  = r.e1 * ctca_pkg::ALPHABET + r.e2;
							rst = r.s2 * ctca_pkg::ALPHABET + r.s1;
							ren = r.e2 * ctca_pkg::ALPHABET + r.e1;
							if (!cherry_mode) begin
								hit = add_quarters(bin, st, en, ctca_pkg::AMT_EDGE);
								hit |= add_quarters(bin, rst, ren, ctca_pkg::AMT_EDGE);
							end else begin
								hit = add_quarters(bin, st, en, ctca_pkg::AMT_CHERRY);
								hit |= add_quarters(bin, en, st, ctca_pkg::AMT_CHERRY);
								hit |= add_quarters(bin, rst, ren, ctca_pkg::AMT_CHERRY);
								hit |= add_quarters(bin, ren, rst, ctca_pkg::AMT_CHERRY);
							end
							want.counted   = 1'b1;
							want.saturated = hit;
							// Remember touched entries so reads can find nonzero counts
							recent_keys = {recent_keys,
								bin * ctca_pkg::MAT_ENTRIES + st * ctca_pkg::PAIRS + en};
							if (recent_keys.size() > 64) void'(recent_keys.pop_front());
						end
					end
				end
				ctca_pkg::REQ_READ: begin
					if (r.bin_select < ctca_pkg::NUM_BINS && r.rrow < ctca_pkg::PAIRS
							&& r.rcol < ctca_pkg::PAIRS) begin
						key = r.bin_select * ctca_pkg::MAT_ENTRIES + r.rrow * ctca_pkg::PAIRS
							+ r.rcol;
						want.count_value = tally.exists(key) ? tally[key] : '0;
					end
				end
				default: ;
			endcase
			pending = {pending, want};
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: count_value %h bin_hit %0d counted %b sat %b",
						got.count_value, got.bin_hit, got.counted, got.saturated);
				return;
			end
			want = pending.pop_front();
			if (got.count_value !== want.count_value || got.bin_hit !== want.bin_hit ||
					got.counted !== want.counted || got.saturated !== want.saturated) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch at %0t: count_value %h/%h bin_hit %0d/%0d ",
						"counted %b/%b sat %b/%b (exp/act)"},
						$realtime, want.count_value, got.count_value, want.bin_hit, got.bin_hit,
						want.counted, got.counted, want.saturated, got.saturated);
			end
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [1:0]                    cfg_index;
	logic [ctca_pkg::RES_W-1:0]    cfg_data;
	logic                          push;
	logic                          full;
	logic [1:0]                    req_type;
	logic [ctca_pkg::BSEL_W-1:0]   bin_select;
	logic [ctca_pkg::LEN_W-1:0]    point_value;
	logic [ctca_pkg::LEN_W-1:0]    length_a;
	logic [ctca_pkg::LEN_W-1:0]    length_b;
	logic [ctca_pkg::RES_W-1:0]    start_first_residue;
	logic [ctca_pkg::RES_W-1:0]    start_second_residue;
	logic [ctca_pkg::RES_W-1:0]    end_first_residue;
	logic [ctca_pkg::RES_W-1:0]    end_second_residue;
	logic [ctca_pkg::PAIR_W-1:0]   read_row;
	logic [ctca_pkg::PAIR_W-1:0]   read_col;
	logic                          empty;
	logic                          pop;
	logic [ctca_pkg::CNT_W-1:0]    count_value;
	logic signed [3:0]             bin_hit;
	logic                          counted;
	logic                          saturated;

	tally_board  board;
	request_t    seen_request;
	result_t     seen_result;
	int          burst_left = 0;
	int          holdoff_asked = 0;
	int          holdoff_served = 0;
	int unsigned cycle_count = 0;

	co_transition_count_accumulator uut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg_valid            (cfg_valid),
		.cfg_ready            (cfg_ready),
		.cfg_index            (cfg_index),
		.cfg_data             (cfg_data),
		.push                 (push),
		.full                 (full),
		.req_type             (req_type),
		.bin_select           (bin_select),
		.point_value          (point_value),
		.length_a             (length_a),
		.length_b             (length_b),
		.start_first_residue  (start_first_residue),
		.start_second_residue (start_second_residue),
		.end_first_residue    (end_first_residue),
		.end_second_residue   (end_second_residue),
		.read_row             (read_row),
		.read_col             (read_col),
		.empty                (empty),
		.pop                  (pop),
		.count_value          (count_value),
		.bin_hit              (bin_hit),
		.counted              (counted),
		.saturated            (saturated)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAIL co_transition_count_accumulator");
			$finish;
		end
	end

	// Sample both handshakes with the values seen just before the edge
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			seen_result.count_value = count_value;
			seen_result.bin_hit     = bin_hit;
			seen_result.counted     = counted;
			seen_result.saturated   = saturated;
			board.check_result(seen_result);
		end
		if (arst_n && push && !full) begin
			seen_request.kind        = ctca_pkg::req_t'(req_type);
			seen_request.bin_select  = bin_select;
			seen_request.point_value = point_value;
			seen_request.length_a    = length_a;
			seen_request.length_b    = length_b;
			seen_request.s1          = start_first_residue;
			seen_request.s2          = start_second_residue;
			seen_request.e1          = end_first_residue;
			seen_request.e2          = end_second_residue;
			seen_request.rrow        = read_row;
			seen_request.rcol        = read_col;
			board.note_request(seen_request);
		end
	end

	// Receiver: stretches of steady, sparse or dense popping, plus a long hold-off on demand
	initial begin : receiver
		int stall_style, run, k;
		pop = 1'b0;
		forever begin
			if (holdoff_asked != holdoff_served) begin
				holdoff_served++;
				pop <= 1'b0;
				for (k = 0; k < HOLDOFF_LEN; k++) @(posedge clk);
			end
			stall_style = $urandom_range(3, 0);
			run = $urandom_range(60, 5);
			for (k = 0; k < run; k++) begin
				case (stall_style)
					0: pop <= 1'b1;
					1: pop <= 1'($urandom_range(1, 0));
					2: pop <= ($urandom_range(4, 0) == 0);
					default: pop <= ($urandom_range(3, 0) != 0);
				endcase
				@(posedge clk);
			end
		end
	end

	function automatic request_t random_request();
		request_t r;
		r.kind        = ctca_pkg::REQ_LOAD;
		r.bin_select  = ctca_pkg::BSEL_W'($urandom);
		r.point_value = $urandom;
		r.length_a    = $urandom;
		r.length_b    = $urandom;
		r.s1          = ctca_pkg::RES_W'($urandom);
		r.s2          = ctca_pkg::RES_W'($urandom);
		r.e1          = ctca_pkg::RES_W'($urandom);
		r.e2          = ctca_pkg::RES_W'($urandom);
		r.rrow        = ctca_pkg::PAIR_W'($urandom);
		r.rcol        = ctca_pkg::PAIR_W'($urandom);
		return r;
	endfunction

	function automatic request_t make_load(bit [ctca_pkg::BSEL_W-1:0] idx,
			bit [ctca_pkg::LEN_W-1:0] value);
		request_t r;
		r = random_request();
		r.kind        = ctca_pkg::REQ_LOAD;
		r.bin_select  = idx;
		r.point_value = value;
		return r;
	endfunction

	function automatic request_t make_count(bit [ctca_pkg::LEN_W-1:0] a,
			bit [ctca_pkg::LEN_W-1:0] b, bit [ctca_pkg::RES_W-1:0] s1,
			bit [ctca_pkg::RES_W-1:0] s2, bit [ctca_pkg::RES_W-1:0] e1,
			bit [ctca_pkg::RES_W-1:0] e2);
		request_t r;
		r = random_request();
		r.kind     = ctca_pkg::REQ_COUNT;
		r.length_a = a;
		r.length_b = b;
		r.s1       = s1;
		r.s2       = s2;
		r.e1       = e1;
		r.e2       = e2;
		return r;
	endfunction

	function automatic request_t make_read(bit [ctca_pkg::BSEL_W-1:0] bin,
			bit [ctca_pkg::PAIR_W-1:0] row, bit [ctca_pkg::PAIR_W-1:0] col);
		request_t r;
		r = random_request();
		r.kind       = ctca_pkg::REQ_READ;
		r.bin_select = bin;
		r.rrow       = row;
		r.rcol       = col;
		return r;
	endfunction

	// Offer one request in bursts with random gaps; return at the accepting edge
	task automatic offer(request_t r);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(20, 1);
			case ($urandom_range(7, 0))
				0, 1:    gap = 0;
				2:       gap = $urandom_range(30, 13);
				default: gap = $urandom_range(12, 1);
			endcase
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		push                 <= 1'b1;
		req_type             <= r.kind;
		bin_select           <= r.bin_select;
		point_value          <= r.point_value;
		length_a             <= r.length_a;
		length_b             <= r.length_b;
		start_first_residue  <= r.s1;
		start_second_residue <= r.s2;
		end_first_residue    <= r.e1;
		end_second_residue   <= r.e2;
		read_row             <= r.rrow;
		read_col             <= r.rcol;
		do @(posedge clk); while (full);
	endtask

	// Stop offering and hold until every expected result has been popped
	task automatic wait_for_results();
		push <= 1'b0;
		do @(posedge clk); while (board.pending.size() != 0);
	endtask

	// Write all three registers back to back, keeping valid high across them
	task automatic configure(bit m, bit [ctca_pkg::RES_W-1:0] s, bit [ctca_pkg::NPT_W-1:0] n);
		logic [1:0]                 idx [3];
		logic [ctca_pkg::RES_W-1:0] val [3];
		idx = '{ctca_pkg::CFG_COUNT_MODE, ctca_pkg::CFG_ALPHA_SIZE, ctca_pkg::CFG_NUM_POINTS};
		val = '{ctca_pkg::RES_W'(m), s, ctca_pkg::RES_W'(n)};
		for (int k = 0; k < 3; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[k];
			cfg_data  <= val[k];
			do @(posedge clk); while (!cfg_ready);
			board.set_register(idx[k], val[k]);
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		request_t                  r;
		int                        p, k, j, n, lim;
		bit [ctca_pkg::LEN_W-1:0]  grid [ctca_pkg::PT_DEPTH];
		bit [ctca_pkg::LEN_W-1:0]  span, val, lo, hi, len, a, b;
		int unsigned               key;

		board                = new();
		arst_n               = 1'b0;
		cfg_valid            = 1'b0;
		cfg_index            = '0;
		cfg_data             = '0;
		push                 = 1'b0;
		req_type             = '0;
		bin_select           = '0;
		point_value          = '0;
		length_a             = '0;
		length_b             = '0;
		start_first_residue  = '0;
		start_second_residue = '0;
		end_first_residue    = '0;
		end_second_residue   = '0;
		read_row             = '0;
		read_col             = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: table of squares 0,1,4,..,49 in Q16.16, edge mode
		configure(1'b0, 5'd20, 4'd8);
		for (k = 0; k < ctca_pkg::PT_DEPTH; k++)
			offer(make_load(ctca_pkg::BSEL_W'(k), ctca_pkg::LEN_W'((k * k) << 16)));
		offer(make_count(32'd0, '1, 5'd0, 5'd0, 5'd0, 5'd0));          // at the first point
		offer(make_count(32'h0000_8000, 32'd0, 5'd19, 5'd19, 5'd19, 5'd19)); // zero left point
		offer(make_count(32'h0002_0000, 32'd0, 5'd1, 5'd2, 5'd3, 5'd4)); // exact tie picks right
		offer(make_count(32'h0001_FFFF, 32'd0, 5'd1, 5'd2, 5'd3, 5'd4)); // just under the tie
		offer(make_count(32'h0031_0000, 32'd0, 5'd5, 5'd6, 5'd7, 5'd8)); // top point
		offer(make_count(32'h0031_0001, 32'd0, 5'd5, 5'd6, 5'd7, 5'd8)); // above the table
		offer(make_count('1, '1, 5'd5, 5'd6, 5'd7, 5'd8));              // largest length
		offer(make_count(32'h0004_0000, 32'd0, 5'd3, 5'd3, 5'd3, 5'd3)); // same entry twice
		offer(make_count(32'h0001_0000, 32'd0, 5'd31, 5'd0, 5'd0, 5'd20)); // bad residues
		offer(make_read(3'd0, 9'd0, 9'd0));
		offer(make_read(3'd1, 9'd399, 9'd399));
		offer(make_read(3'd2, 9'd22, 9'd64));
		offer(make_read(3'd2, 9'd63, 9'd63));
		offer(make_read(3'd7, 9'd106, 9'd148));
		offer(make_read(3'd7, 9'd511, 9'd511));                        // outside the matrix
		r = make_count('1, '1, 5'd31, 5'd31, 5'd31, 5'd31);
		r.kind        = ctca_pkg::REQ_NONE;
		r.bin_select  = '1;
		r.point_value = '1;
		r.rrow        = '1;
		r.rcol        = '1;
		offer(r);

		// Directed: cherry mode
		wait_for_results();
		configure(1'b1, 5'd20, 4'd8);
		offer(make_count('1, '1, 5'd0, 5'd0, 5'd0, 5'd0));             // sum overflows 32 bits
		offer(make_count(32'h0001_0000, 32'h0001_0000, 5'd1, 5'd2, 5'd1, 5'd2));
		offer(make_read(3'd2, 9'd22, 9'd22));
		offer(make_count(32'h0030_0000, 32'h0001_0000, 5'd9, 5'd10, 5'd11, 5'd12));
		offer(make_read(3'd7, 9'd232, 9'd190));
		offer(make_load(3'd7, '1));
		offer(make_count('1, 32'd0, 5'd19, 5'd0, 5'd0, 5'd19));        // largest products

		// Random phases: sorted table with random content, then mixed requests
		for (p = 0; p < NUM_PHASES; p++) begin
			wait_for_results();
			configure(PHASE_MODE[p], PHASE_STATES[p], PHASE_POINTS[p]);
			if (p == 1 || p == 7) holdoff_asked++;
			case ($urandom_range(3, 0))
				0:       span = 32'h0000_03FF;
				1:       span = 32'h000F_FFFF;
				2:       span = 32'h0FFF_FFFF;
				default: span = 32'h1C00_0000;
			endcase
			val = ($urandom_range(3, 0) == 0) ? 32'd0 : $urandom_range(span, 0);
			for (k = 0; k < ctca_pkg::PT_DEPTH; k++) begin
				grid[k] = val;
				offer(make_load(ctca_pkg::BSEL_W'(k), val));
				val = val + $urandom_range(span, 0);
			end
			if ($urandom_range(3, 0) == 0) begin
				grid[ctca_pkg::PT_DEPTH-1] = '1;
				offer(make_load(ctca_pkg::BSEL_W'(ctca_pkg::PT_DEPTH - 1), '1));
			end
			n = (PHASE_POINTS[p] > ctca_pkg::PT_DEPTH) ? ctca_pkg::PT_DEPTH : PHASE_POINTS[p];
			if (n == 0) n = ctca_pkg::PT_DEPTH;
			lim = (PHASE_STATES[p] < ctca_pkg::ALPHABET) ? PHASE_STATES[p] : ctca_pkg::ALPHABET;

			for (k = 0; k < PHASE_ITEMS; k++) begin
				j = $urandom_range(99, 0);
				if (j < 60) begin
					// Mostly lengths inside the table, some just outside, some anywhere
					j = $urandom_range(99, 0);
					if (j < 80) begin
						j  = $urandom_range(n - 1, 0);
						lo = grid[j];
						hi = (j + 1 < n) ? grid[j+1] : grid[j];
						if (hi < lo) hi = lo;
						len = ($urandom_range(9, 0) == 0) ? lo : $urandom_range(hi, lo);
					end else if (j < 90) begin
						len = $urandom_range(1, 0) ? grid[0] - 1 : grid[n-1] + 1;
					end else begin
						len = $urandom;
					end
					if (PHASE_MODE[p]) begin
						a = $urandom_range(len, 0);
						b = len - a;
						if (j >= 90) begin
							a = $urandom;
							b = $urandom;
						end
					end else begin
						a = len;
						b = $urandom;
					end
					if ($urandom_range(99, 0) < 85 && lim > 0)
						r = make_count(a, b,
							ctca_pkg::RES_W'($urandom_range(lim - 1, 0)),
							ctca_pkg::RES_W'($urandom_range(lim - 1, 0)),
							ctca_pkg::RES_W'($urandom_range(lim - 1, 0)),
							ctca_pkg::RES_W'($urandom_range(lim - 1, 0)));
					else
						r = make_count(a, b, ctca_pkg::RES_W'($urandom),
							ctca_pkg::RES_W'($urandom), ctca_pkg::RES_W'($urandom),
							ctca_pkg::RES_W'($urandom));
				end else if (j < 90) begin
					// Read back touched entries mostly, otherwise anywhere including outside
					if ($urandom_range(9, 0) < 7 && board.recent_keys.size() > 0) begin
						key = board.recent_keys[$urandom_range(board.recent_keys.size() - 1, 0)];
						r = make_read(ctca_pkg::BSEL_W'(key / ctca_pkg::MAT_ENTRIES),
							ctca_pkg::PAIR_W'((key % ctca_pkg::MAT_ENTRIES) / ctca_pkg::PAIRS),
							ctca_pkg::PAIR_W'(key % ctca_pkg::PAIRS));
					end else begin
						r = make_read(ctca_pkg::BSEL_W'($urandom),
							ctca_pkg::PAIR_W'($urandom_range(1, 0) ? $urandom_range(511, 0)
								: $urandom_range(ctca_pkg::PAIRS - 1, 0)),
							ctca_pkg::PAIR_W'($urandom_range(511, 0)));
					end
				end else if (j < 95) begin
					// Stray load: may leave the table unsorted
					r = make_load(ctca_pkg::BSEL_W'($urandom), $urandom);
					grid[r.bin_select] = r.point_value;
				end else begin
					r = random_request();
					r.kind = ctca_pkg::REQ_NONE;
				end
				offer(r);
			end
		end

		// Drain and let any stray result show up
		wait_for_results();
		repeat (40) @(posedge clk);
		if (board.pending.size() != 0)
			$display("%0d expected results never arrived", board.pending.size());
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("PASS co_transition_count_accumulator");
		else
			$display("FAIL co_transition_count_accumulator");
		$finish;
	end

endmodule

// ===== files.f =====
sv/ctca_pkg.sv
sv/ctca_front.sv
sv/ctca_cmdq.sv
sv/ctca_back.sv
sv/co_transition_count_accumulator.sv
test/tb_co_transition_count_accumulator.sv
